### design/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg: shared types, codes and helpers
// Command and status structs between controller and datapath, protocol
// codes, and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrs_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_HOLDING_DEPTH  = 256;
    localparam int DEF_MAX_READ_COUNT = 125;

    // Configuration register indexes
    localparam logic REG_SLAVE_ADDRESS = 1'b0;
    localparam logic REG_HOLDING_COUNT = 1'b1;

    // Input commands
    localparam logic [1:0] CMD_FRAME_BYTE  = 2'd0;
    localparam logic [1:0] CMD_LOCAL_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOCAL_READ  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_RESPONSE  = 3'd0;
    localparam logic [2:0] ST_CRC_FAIL  = 3'd1;
    localparam logic [2:0] ST_NOT_ADDR  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_LOCAL_RD  = 3'd4;

    // Function and exception codes
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FC  = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADR = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VAL = 8'h03;

    localparam logic [7:0]  BROADCAST_ADDR = 8'h00;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd4;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LREAD,
        S_CHECK,
        S_STATUS,
        S_EMIT,
        S_FETCH
    } state_t;

    typedef enum logic [1:0] {
        KIND_EXC,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic check;
        logic emit;
        logic fetch;
        logic push_beat;
        logic push_status;
        logic push_lread;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_status;
        logic pack_full;
        logic has_bytes;
        logic tx_done;
        logic need_fetch;
        logic out_free;
    } dp_status_t;

    // One byte into a reflected CRC-16/MODBUS
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### design/mrs_ram.sv
// ----------------------------------------------------------------------------
// mrs_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered and held
// while the read enable is low.
// ----------------------------------------------------------------------------
module mrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/mrs_ctrl.sv
// ----------------------------------------------------------------------------
// mrs_ctrl: server sequencer
// Sweeps the memory after reset, accepts items, checks a finished frame
// and walks the response bytes out in beats.
// ----------------------------------------------------------------------------
module mrs_ctrl
    import mrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] command,
    input  logic       end_of_frame,
    input  dp_status_t st,
    output logic       in_stall,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (command == CMD_FRAME_BYTE && end_of_frame)
                        state_next = S_CHECK;
                    else if (command == CMD_LOCAL_READ)
                        state_next = S_LREAD;
                end
            end
            S_LREAD:
            begin
                if (st.out_free)
                begin
                    cmd.push_lread = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = st.is_status ? S_STATUS : S_EMIT;
            end
            S_STATUS:
            begin
                if (st.out_free)
                begin
                    cmd.push_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (st.pack_full || (st.tx_done && st.has_bytes))
                begin
                    if (st.out_free)
                    begin
                        cmd.push_beat = 1'b1;
                        if (st.tx_done)
                            state_next = S_IDLE;
                    end
                end
                else if (st.tx_done)
                    state_next = S_IDLE;
                else if (st.need_fetch)
                    state_next = S_FETCH;
                else
                    cmd.emit = 1'b1;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EMIT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### design/mrs_dp.sv
// ----------------------------------------------------------------------------
// mrs_dp: server datapath
// Configuration, frame capture with running CRC, request decode, response
// byte builder with transmit CRC, beat packing and the output register.
// ----------------------------------------------------------------------------
module mrs_dp
    import mrs_pkg::*;
#(
    parameter int HOLDING_DEPTH  = DEF_HOLDING_DEPTH,
    parameter int MAX_READ_COUNT = DEF_MAX_READ_COUNT,
    localparam int AW = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  local_index,
    input  logic [15:0] local_value,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  st,
    output logic        mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [15:0] mem_wdata,
    output logic        mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [15:0] mem_rdata,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [31:0] resp_data,
    output logic [2:0]  resp_bytes,
    output logic        resp_last,
    output logic [2:0]  frame_status,
    output logic [15:0] read_value
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(HOLDING_DEPTH - 1);

    // Configuration
    logic [7:0] slave_addr_reg;
    logic [8:0] hold_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
            hold_count_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS: slave_addr_reg <= cfg_data[7:0];
                REG_HOLDING_COUNT: hold_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state
    logic [15:0] count_reg;
    logic [15:0] crc_reg;
    logic [15:0] tail_reg;
    logic [7:0]  hdr_reg [6];
    logic        byte_in;

    assign byte_in = cmd.accept && (command == CMD_FRAME_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            tail_reg  <= '0;
            for (int k = 0; k < 6; k++)
                hdr_reg[k] <= '0;
        end
        else if (cmd.check)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            tail_reg  <= '0;
            for (int k = 0; k < 6; k++)
                hdr_reg[k] <= '0;
        end
        else if (byte_in)
        begin
            // CRC lags two bytes behind so the trailer stays out of it
            if (count_reg >= 16'd2)
                crc_reg <= crc_feed(crc_reg, tail_reg[15:8]);
            tail_reg <= {tail_reg[7:0], rx_byte};
            for (int k = 0; k < 6; k++)
                if (count_reg == 16'(k))
                    hdr_reg[k] <= rx_byte;
            if (count_reg != 16'hFFFF)
                count_reg <= count_reg + 16'd1;
        end
    end

    // Request decode
    logic [15:0] req_a, req_b;
    logic [7:0]  req_fc;
    logic [16:0] regs_use;
    logic        is_short, crc_bad, is_bcast, not_me, bcast_write;
    logic [2:0]  verdict;
    kind_t       kind_d;
    logic [7:0]  fc_out_d, exc_code_d, body_len_d;
    logic        mem_write_d;

    assign req_fc = hdr_reg[1];
    assign req_a  = {hdr_reg[2], hdr_reg[3]};
    assign req_b  = {hdr_reg[4], hdr_reg[5]};
    assign regs_use = (32'(hold_count_reg) > HOLDING_DEPTH) ? 17'(HOLDING_DEPTH)
                                                           : 17'(hold_count_reg);
    assign is_short = count_reg < MIN_FRAME_LEN;
    assign crc_bad  = {tail_reg[7:0], tail_reg[15:8]} != crc_reg;
    assign is_bcast = hdr_reg[0] == BROADCAST_ADDR;
    assign not_me   = hdr_reg[0] != slave_addr_reg;
    assign bcast_write = (req_fc == FC_WRITE_SINGLE) && (17'(req_a) < regs_use);

    always_comb
    begin
        if (is_short)
            verdict = ST_SHORT;
        else if (crc_bad)
            verdict = ST_CRC_FAIL;
        else if (is_bcast || not_me)
            verdict = ST_NOT_ADDR;
        else
            verdict = ST_RESPONSE;
    end

    always_comb
    begin
        kind_d      = KIND_EXC;
        fc_out_d    = req_fc | FC_EXC_FLAG;
        exc_code_d  = EXC_ILLEGAL_FC;
        body_len_d  = 8'd3;
        mem_write_d = 1'b0;
        if (req_fc == FC_READ_HOLDING)
        begin
            if (req_b == 16'd0 || 32'(req_b) > MAX_READ_COUNT)
                exc_code_d = EXC_ILLEGAL_VAL;
            else if (17'(req_a) + 17'(req_b) > regs_use)
                exc_code_d = EXC_ILLEGAL_ADR;
            else
            begin
                kind_d     = KIND_READ;
                fc_out_d   = req_fc;
                body_len_d = {req_b[6:0], 1'b0} + 8'd3;
            end
        end
        else if (req_fc == FC_WRITE_SINGLE)
        begin
            if (17'(req_a) >= regs_use)
                exc_code_d = EXC_ILLEGAL_ADR;
            else
            begin
                kind_d      = KIND_WRITE;
                fc_out_d    = req_fc;
                body_len_d  = 8'd6;
                mem_write_d = 1'b1;
            end
        end
        // Broadcast writes land without a reply
        if (verdict == ST_NOT_ADDR)
            mem_write_d = is_bcast && bcast_write;
        else if (verdict != ST_RESPONSE)
            mem_write_d = 1'b0;
    end

    // Response latch and byte walker
    kind_t       kind_reg;
    logic [7:0]  fc_out_reg, exc_code_reg, body_len_reg, total_reg, idx_reg;
    logic [15:0] a_reg, b_reg, rd_ptr_reg, tx_crc_reg;
    logic [2:0]  status_reg;
    logic [31:0] pack_reg;
    logic [2:0]  pos_reg;
    logic        have_data_reg;
    logic [7:0]  body_byte, emit_byte;

    always_comb
    begin
        body_byte = 8'h00;
        if (idx_reg == 8'd0)
            body_byte = slave_addr_reg;
        else if (idx_reg == 8'd1)
            body_byte = fc_out_reg;
        else
        begin
            case (kind_reg)
                KIND_EXC:   body_byte = exc_code_reg;
                KIND_WRITE:
                begin
                    case (idx_reg[1:0])
                        2'd2:    body_byte = a_reg[15:8];
                        2'd3:    body_byte = a_reg[7:0];
                        2'd0:    body_byte = b_reg[15:8];
                        default: body_byte = b_reg[7:0];
                    endcase
                end
                default:
                begin
                    if (idx_reg == 8'd2)
                        body_byte = {b_reg[6:0], 1'b0};
                    else if (idx_reg[0])
                        body_byte = mem_rdata[15:8];
                    else
                        body_byte = mem_rdata[7:0];
                end
            endcase
        end
    end

    always_comb
    begin
        if (idx_reg < body_len_reg)
            emit_byte = body_byte;
        else if (idx_reg == body_len_reg)
            emit_byte = tx_crc_reg[7:0];
        else
            emit_byte = tx_crc_reg[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            total_reg     <= '0;
            pos_reg       <= '0;
            have_data_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            idx_reg       <= '0;
            total_reg     <= body_len_d + 8'd2;
            pos_reg       <= '0;
            have_data_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fetch)
                have_data_reg <= 1'b1;
            if (cmd.emit)
            begin
                have_data_reg <= 1'b0;
                idx_reg       <= idx_reg + 8'd1;
                pos_reg       <= pos_reg + 3'd1;
            end
            else if (cmd.push_beat)
                pos_reg <= '0;
        end
    end

    // Response payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            kind_reg     <= kind_d;
            fc_out_reg   <= fc_out_d;
            exc_code_reg <= exc_code_d;
            body_len_reg <= body_len_d;
            a_reg        <= req_a;
            b_reg        <= req_b;
            rd_ptr_reg   <= req_a;
            status_reg   <= verdict;
            tx_crc_reg   <= CRC_INIT;
            pack_reg     <= '0;
        end
        else
        begin
            if (cmd.fetch)
                rd_ptr_reg <= rd_ptr_reg + 16'd1;
            if (cmd.emit)
            begin
                if (idx_reg < body_len_reg)
                    tx_crc_reg <= crc_feed(tx_crc_reg, body_byte);
                case (pos_reg[1:0])
                    2'd0:    pack_reg[31:24] <= emit_byte;
                    2'd1:    pack_reg[23:16] <= emit_byte;
                    2'd2:    pack_reg[15:8]  <= emit_byte;
                    default: pack_reg[7:0]   <= emit_byte;
                endcase
            end
            else if (cmd.push_beat)
                pack_reg <= '0;
        end
    end

    // Local read bookkeeping and clearing sweep
    logic          lread_ok_reg;
    logic [AW-1:0] sweep_reg;
    logic          local_ok;

    assign local_ok = 32'(local_index) < HOLDING_DEPTH;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            lread_ok_reg <= local_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.clear_step)
            sweep_reg <= sweep_reg + AW'(1);
    end

    // Memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(local_index);
        mem_wdata = local_value;
        mem_re    = 1'b0;
        mem_raddr = AW'(local_index);
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
        else if (cmd.check)
        begin
            mem_we    = mem_write_d;
            mem_waddr = AW'(req_a);
            mem_wdata = req_b;
        end
        else if (cmd.accept)
        begin
            mem_we = (command == CMD_LOCAL_WRITE) && local_ok;
            mem_re = (command == CMD_LOCAL_READ);
        end
        else if (cmd.fetch)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(rd_ptr_reg);
        end
    end

    // Output register
    logic        out_valid_reg;
    logic [31:0] data_reg;
    logic [2:0]  bytes_reg, fstat_reg;
    logic        last_reg;
    logic [15:0] rval_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push_beat || cmd.push_status || cmd.push_lread)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_beat)
        begin
            data_reg  <= pack_reg;
            bytes_reg <= pos_reg;
            last_reg  <= (idx_reg == total_reg);
            fstat_reg <= ST_RESPONSE;
            rval_reg  <= '0;
        end
        else if (cmd.push_status)
        begin
            data_reg  <= '0;
            bytes_reg <= '0;
            last_reg  <= 1'b1;
            fstat_reg <= status_reg;
            rval_reg  <= '0;
        end
        else if (cmd.push_lread)
        begin
            data_reg  <= '0;
            bytes_reg <= '0;
            last_reg  <= 1'b1;
            fstat_reg <= ST_LOCAL_RD;
            rval_reg  <= lread_ok_reg ? mem_rdata : 16'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign resp_data    = data_reg;
    assign resp_bytes   = bytes_reg;
    assign resp_last    = last_reg;
    assign frame_status = fstat_reg;
    assign read_value   = rval_reg;

    // Status to the controller
    assign st.clear_done = sweep_reg == LAST_ADDR;
    assign st.is_status  = verdict != ST_RESPONSE;
    assign st.pack_full  = pos_reg == 3'd4;
    assign st.has_bytes  = pos_reg != 3'd0;
    assign st.tx_done    = idx_reg == total_reg;
    assign st.need_fetch = (kind_reg == KIND_READ) && (idx_reg >= 8'd3)
                           && (idx_reg < body_len_reg) && idx_reg[0] && !have_data_reg;
    assign st.out_free   = out_free;

endmodule

### design/modbus_rtu_register_server.sv
// ----------------------------------------------------------------------------
// modbus_rtu_register_server: RTU holding-register server (0x03 / 0x06)
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries received frame bytes with an
// end-of-frame mark, or local register writes and reads. Output channel
// (out_valid / out_stall) carries response beats of up to four bytes, first
// byte in resp_data[31:24], with resp_last on the final beat.
// A mid-frame byte or local write is taken without leaving the idle state. A
// local read reads the memory at transfer; its value is registered into the
// output register once that is free. At frame end a check state decides; a
// status-only result follows once the output register is free, a response is
// built one byte per cycle while no beat waits on the output, with a memory
// fetch before each register's bytes on a read. The single memory read port
// and the byte-wide transmit CRC set this pace. No new item is taken until
// the previous item's results are all in the output register.
// After reset the holding memory is cleared word by word with in_stall high;
// configuration writes are taken meanwhile. While out_stall is high the
// output register holds its beat and the builder waits to push.
// ----------------------------------------------------------------------------
module modbus_rtu_register_server
    import mrs_pkg::*;
#(
    parameter int HOLDING_DEPTH  = DEF_HOLDING_DEPTH,
    parameter int MAX_READ_COUNT = DEF_MAX_READ_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_frame,
    input  logic [7:0]  local_index,
    input  logic [15:0] local_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] resp_data,
    output logic [2:0]  resp_bytes,
    output logic        resp_last,
    output logic [2:0]  frame_status,
    output logic [15:0] read_value
);

    localparam int AW = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;

    ctrl_cmd_t     cmd;
    dp_status_t    st;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;

    mrs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .command      (command),
        .end_of_frame (end_of_frame),
        .st           (st),
        .in_stall     (in_stall),
        .cmd          (cmd)
    );

    mrs_dp #(
        .HOLDING_DEPTH  (HOLDING_DEPTH),
        .MAX_READ_COUNT (MAX_READ_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .rx_byte      (rx_byte),
        .local_index  (local_index),
        .local_value  (local_value),
        .cmd          (cmd),
        .st           (st),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .resp_data    (resp_data),
        .resp_bytes   (resp_bytes),
        .resp_last    (resp_last),
        .frame_status (frame_status),
        .read_value   (read_value)
    );

    mrs_ram #(
        .WIDTH (16),
        .DEPTH (HOLDING_DEPTH)
    ) u_hold_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
